/* rtl/mghf_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the magnetometer/gyro heading fusion block.
// Holds the CORDIC word formats, the arctangent table and the register indices.
package mghf_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_DEPTH = 24;

	localparam int XW = 28;
	localparam int ZW = 26;

	localparam logic signed [ZW-1:0] DEG90_FINE = 26'sd5898240;
	localparam logic signed [17:0] FULL_TURN = 18'sd46080;
	localparam logic signed [17:0] QUARTER_TURN = 18'sd11520;

	localparam logic [16:0] MAG_WEIGHT_RST = 17'd45875;
	localparam logic [23:0] GYRO_GAIN_RST = 24'd25166;

	localparam logic signed [ZW-1:0] ATAN_TABLE [ATAN_DEPTH] = '{
		26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
		26'sd234379, 26'sd117304, 26'sd58666, 26'sd29335,
		26'sd14668, 26'sd7334, 26'sd3667, 26'sd1833,
		26'sd917, 26'sd458, 26'sd229, 26'sd115,
		26'sd57, 26'sd29, 26'sd14, 26'sd7,
		26'sd4, 26'sd2, 26'sd1, 26'sd0
	};

	typedef enum logic [1:0] {
		REG_MAG_WEIGHT = 2'd0,
		REG_GYRO_GAIN  = 2'd1
	} cfg_reg_e_t;

	typedef struct packed {
		logic                 zero;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} cordic_t;

endpackage

/* rtl/mghf_cordic_cell.sv */
`timescale 1ns / 1ps
// One vectoring CORDIC iteration with its output register.
// Depends on mghf_pkg for the word format and the arctangent table.
module mghf_cordic_cell import mghf_pkg::*; #(
	parameter int STEP = 0
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_vld,
	input  cordic_t din,
	output logic    out_vld,
	output cordic_t dout
);

	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;
	cordic_t nxt;
	logic vld_q;
	cordic_t data_q;

	always_comb begin
		xs = din.x >>> STEP;
		ys = din.y >>> STEP;
		nxt = din;
		if (din.y > 0) begin
			nxt.x = din.x + ys;
			nxt.y = din.y - xs;
			nxt.z = din.z + ATAN_TABLE[STEP];
		end else begin
			nxt.x = din.x - ys;
			nxt.y = din.y + xs;
			nxt.z = din.z - ATAN_TABLE[STEP];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= nxt;
	end

	assign out_vld = vld_q;
	assign dout = data_q;

endmodule

/* rtl/mag_gyro_heading_fusion.sv */
`timescale 1ns / 1ps
// Top level of the magnetometer/gyro heading fusion block.
// Depends on mghf_pkg and instantiates a chain of mghf_cordic_cell.
//
// Input items arrive on s_tvalid/s_tready/s_tdata and carry one raw
// magnetometer X/Y sample and a yaw rate. Each item gives one result on
// m_tvalid/m_tready/m_tdata: the fused angle and the calibrated heading.
// The two filter registers are written through cfg_valid/cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high.
// One item is worked on at a time. Once it is accepted, it passes through
// the input register, the row of CORDIC cells, one cell per iteration, and
// the heading, error, product and output stages. The next item can be
// accepted once the result of the last one is loaded into the output register.
// A finished result waits in the output register while the receiver
// stalls; the next item may then be accepted and is held before the output
// until the register is free.
// Reset clears the calibration extremes, the filter state and the seeding
// flag, and returns both registers to their default weights.
module mag_gyro_heading_fusion import mghf_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // mag_x [15:0], mag_y [31:16], gyro_rate [47:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // fused_angle [31:0], mag_heading [47:32]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	logic in_acc;
	logic signed [15:0] s_mx, s_my, s_rate;

	logic busy_q;
	logic [16:0] mag_weight_q;
	logic [23:0] gyro_gain_q;
	logic signed [15:0] x_max_q, x_min_q, y_max_q, y_min_q;
	logic signed [31:0] prev_q;
	logic seeded_q;

	logic v_s1;
	logic signed [15:0] mx_s1, my_s1, rate_s1;

	logic signed [16:0] xsum, ysum, xrnd, yrnd;
	logic signed [15:0] xoff, yoff;
	logic signed [17:0] cx, cy;
	logic signed [XW-1:0] sx, sy;
	cordic_t c0;

	cordic_t chain_d [CORDIC_STEPS+1];
	logic    chain_v [CORDIC_STEPS+1];

	logic signed [ZW-1:0] zf, zr;
	logic signed [16:0] ang;
	logic signed [17:0] h0, h1, h2;
	logic hd_vld_s2;
	logic [15:0] hd_s2;

	logic signed [31:0] pv;
	logic v_s3;
	logic signed [32:0] diff_s3;
	logic signed [31:0] pv_s3;
	logic signed [40:0] gp_s3;

	logic v_s4;
	logic signed [50:0] ep_s4;

	logic signed [50:0] err_rnd;
	logic signed [40:0] inc_rnd;
	logic signed [34:0] err;
	logic signed [19:0] inc;
	logic signed [35:0] sum;
	logic signed [31:0] sat;
	logic out_load;

	logic m_tvalid_q;
	logic [47:0] m_tdata_q;

	assign s_tready = !busy_q;
	assign in_acc = s_tvalid && s_tready;
	assign s_mx = s_tdata[15:0];
	assign s_my = s_tdata[31:16];
	assign s_rate = s_tdata[47:32];
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_weight_q <= MAG_WEIGHT_RST;
			gyro_gain_q <= GYRO_GAIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MAG_WEIGHT: mag_weight_q <= cfg_data[16:0];
				REG_GYRO_GAIN: gyro_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_max_q <= '0;
			x_min_q <= '0;
			y_max_q <= '0;
			y_min_q <= '0;
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_acc;
			if (in_acc) begin
				if (s_mx > x_max_q) x_max_q <= s_mx;
				if (s_mx < x_min_q) x_min_q <= s_mx;
				if (s_my > y_max_q) y_max_q <= s_my;
				if (s_my < y_min_q) y_min_q <= s_my;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mx_s1 <= s_mx;
			my_s1 <= s_my;
			rate_s1 <= s_rate;
		end
	end

	// Hard-iron offset is half the sum of the extremes, truncated toward zero.
	always_comb begin
		xsum = {x_max_q[15], x_max_q} + {x_min_q[15], x_min_q};
		ysum = {y_max_q[15], y_max_q} + {y_min_q[15], y_min_q};
		xrnd = xsum + {16'd0, xsum[16]};
		yrnd = ysum + {16'd0, ysum[16]};
		xoff = xrnd[16:1];
		yoff = yrnd[16:1];
		cx = {{2{mx_s1[15]}}, mx_s1} - {{2{xoff[15]}}, xoff};
		cy = {{2{my_s1[15]}}, my_s1} - {{2{yoff[15]}}, yoff};
		sx = {{(XW-26){cx[17]}}, cx, 8'd0};
		sy = {{(XW-26){cy[17]}}, cy, 8'd0};
		c0.zero = (cx == '0) && (cy == '0);
		c0.x = sx;
		c0.y = sy;
		c0.z = '0;
		if (sx < 0) begin
			if (sy >= 0) begin
				c0.x = sy;
				c0.y = -sx;
				c0.z = DEG90_FINE;
			end else begin
				c0.x = -sy;
				c0.y = sx;
				c0.z = -DEG90_FINE;
			end
		end
	end

	assign chain_d[0] = c0;
	assign chain_v[0] = v_s1;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		mghf_cordic_cell #(
			.STEP(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.in_vld(chain_v[i]),
			.din(chain_d[i]),
			.out_vld(chain_v[i+1]),
			.dout(chain_d[i+1])
		);
	end

	// Accumulator to 1/128 degree, shifted by a quarter turn into (0,360].
	always_comb begin
		zf = chain_d[CORDIC_STEPS].zero ? '0 : chain_d[CORDIC_STEPS].z;
		zr = zf + ZW'(256);
		ang = zr[ZW-1:9];
		h0 = (ang > 0) ? {ang[16], ang} : {ang[16], ang} + FULL_TURN;
		h1 = h0 + QUARTER_TURN;
		h2 = (h1 > FULL_TURN) ? h1 - FULL_TURN : h1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hd_vld_s2 <= 1'b0;
		end else begin
			hd_vld_s2 <= chain_v[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (chain_v[CORDIC_STEPS]) begin
			hd_s2 <= h2[15:0];
		end
	end

	assign pv = seeded_q ? prev_q : {16'd0, hd_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			seeded_q <= 1'b0;
		end else begin
			v_s3 <= hd_vld_s2;
			if (hd_vld_s2) seeded_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (hd_vld_s2) begin
			diff_s3 <= {17'd0, hd_s2} - {pv[31], pv};
			pv_s3 <= pv;
			gp_s3 <= rate_s1 * $signed({1'b0, gyro_gain_q});
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3) begin
			ep_s4 <= diff_s3 * $signed({1'b0, mag_weight_q});
		end
	end

	always_comb begin
		err_rnd = ep_s4 + 51'sd32768;
		inc_rnd = gp_s3 + 41'sd1048576;
		err = err_rnd[50:16];
		inc = inc_rnd[40:21];
		sum = {{4{pv_s3[31]}}, pv_s3} + {err[34], err} + {{16{inc[19]}}, inc};
		if (sum[35:31] == 5'b00000 || sum[35:31] == 5'b11111) begin
			sat = sum[31:0];
		end else if (sum[35]) begin
			sat = 32'sh8000_0000;
		end else begin
			sat = 32'sh7FFF_FFFF;
		end
	end

	assign out_load = v_s4 && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			busy_q <= 1'b0;
			m_tvalid_q <= 1'b0;
			prev_q <= '0;
		end else begin
			if (v_s3) begin
				v_s4 <= 1'b1;
			end else if (out_load) begin
				v_s4 <= 1'b0;
			end
			if (in_acc) begin
				busy_q <= 1'b1;
			end else if (out_load) begin
				busy_q <= 1'b0;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
				prev_q <= sat;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {hd_s2, sat};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	a_one_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({v_s1, hd_vld_s2, v_s3, v_s4}))
		else $error("More than one item is in flight.");

	a_busy_block: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 || hd_vld_s2 || v_s3 || v_s4) |-> !s_tready)
		else $error("Input is ready while an item is being worked on.");

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (m_tdata[47:32] != 16'd0 && m_tdata[47:32] <= 16'd46080))
		else $error("Heading is outside its range.");

	a_prev_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (prev_q == $signed(m_tdata[31:0])))
		else $error("Filter state differs from the delivered angle.");

endmodule
